>>> sv/wbml_pkg.sv
// wbml_pkg: shared types and constants of the weighted book move lookup
// used by the controller, the datapath and the top level
// depends on nothing
`default_nettype none

package wbml_pkg;

  // field widths fixed by the item format
  localparam int unsigned KEY_W         = 64;
  localparam int unsigned MOVE_W        = 16;
  localparam int unsigned WEIGHT_W      = 16;
  localparam int unsigned SLOT_W        = 12;
  localparam int unsigned SQUARE_W      = 6;
  localparam int unsigned TOTAL_W       = 28;
  localparam int unsigned SEED_W        = 31;
  localparam int unsigned ENTRY_COUNT_W = 13;
  localparam int unsigned CFG_DATA_W    = 31;
  localparam int unsigned RAND_BIT_W    = 5;

  // saturation value of the reported weight sum
  localparam logic [TOTAL_W-1:0] WEIGHT_SAT = 28'hFFFFFFF;

  // seed value after reset
  localparam logic [SEED_W-1:0] SEED_RESET = 31'd1;

  // lfsr taps for x^31 + x^28 + 1
  localparam int unsigned LFSR_TAP_HI = 30;
  localparam int unsigned LFSR_TAP_LO = 27;

  // packed move fields
  localparam logic [2:0] FIELD_MASK3 = 3'b111;
  localparam logic [2:0] FILE_A      = 3'd0;
  localparam logic [2:0] FILE_C      = 3'd2;
  localparam logic [2:0] FILE_E      = 3'd4;
  localparam logic [2:0] FILE_G      = 3'd6;
  localparam logic [2:0] FILE_H      = 3'd7;

  // opcode of an input item
  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_ENTRY_COUNT = 1'b0,
    REG_RANDOM_SEED = 1'b1
  } cfg_reg_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_FOUND       = 2'd0,
    ST_NO_ENTRY    = 2'd1,
    ST_ZERO_WEIGHT = 2'd2,
    ST_EMPTY       = 2'd3
  } status_e;

  // status register update requested by the controller
  typedef enum logic [1:0] {
    STAT_NONE     = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_ZERO     = 2'd2,
    STAT_SCAN_END = 2'd3
  } stat_op_e;

  // table read address source
  typedef enum logic [1:0] {
    RD_MID  = 2'd0,
    RD_LEFT = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_SRCH     = 3'd1,
    S_SRCH_CMP = 3'd2,
    S_SCAN     = 3'd3,
    S_MOD      = 3'd4,
    S_SEL      = 3'd5,
    S_RESULT   = 3'd6
  } fsm_state_e;

  // one table entry
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [MOVE_W-1:0]   move;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;
    logic     q_init;
    logic     srch_upd;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     pos_init;
    logic     scan_step;
    logic     mod_step;
    logic     sel_step;
    stat_op_e stat_op;
    logic     out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic n_zero;
    logic lt;
    logic key_eq;
    logic w_zero;
    logic mod_last;
    logic more;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/wbml_ctrl.sv
// wbml_ctrl: controller state machine of the book move lookup
// sequences load, binary search, match scan, remainder steps and result
// depends on wbml_pkg
`default_nettype none

module wbml_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_opcode_i,
  output logic                in_ready_o,
  input  wbml_pkg::sts_t      sts_i,
  output wbml_pkg::cmd_t      cmd_o
);

  wbml_pkg::fsm_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wbml_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      wbml_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == wbml_pkg::OP_QUERY) begin
            cmd_o.q_init = 1'b1;
            if (sts_i.n_zero) begin
              cmd_o.stat_op = wbml_pkg::STAT_EMPTY;
              state_d       = wbml_pkg::S_RESULT;
            end else begin
              state_d = wbml_pkg::S_SRCH;
            end
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      // probe the middle slot, or fetch the lower bound when the range is closed
      wbml_pkg::S_SRCH: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.lt) begin
          cmd_o.rd_sel = wbml_pkg::RD_MID;
          state_d      = wbml_pkg::S_SRCH_CMP;
        end else begin
          cmd_o.rd_sel   = wbml_pkg::RD_LEFT;
          cmd_o.pos_init = 1'b1;
          state_d        = wbml_pkg::S_SCAN;
        end
      end
      wbml_pkg::S_SRCH_CMP: begin
        cmd_o.srch_upd = 1'b1;
        state_d        = wbml_pkg::S_SRCH;
      end
      // check the fetched entry of the run
      wbml_pkg::S_SCAN: begin
        if (!sts_i.key_eq) begin
          cmd_o.stat_op = wbml_pkg::STAT_SCAN_END;
          state_d       = wbml_pkg::S_RESULT;
        end else if (sts_i.w_zero) begin
          cmd_o.stat_op = wbml_pkg::STAT_ZERO;
          state_d       = wbml_pkg::S_RESULT;
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d         = wbml_pkg::S_MOD;
        end
      end
      wbml_pkg::S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = wbml_pkg::S_SEL;
        end
      end
      // take the pick decision, then fetch the next slot or finish
      wbml_pkg::S_SEL: begin
        cmd_o.sel_step = 1'b1;
        if (sts_i.more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = wbml_pkg::RD_NEXT;
          state_d      = wbml_pkg::S_SCAN;
        end else begin
          cmd_o.stat_op = wbml_pkg::STAT_SCAN_END;
          state_d       = wbml_pkg::S_RESULT;
        end
      end
      wbml_pkg::S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = wbml_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wbml_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/wbml_datapath.sv
// wbml_datapath: table memory, search and scan registers, lfsr,
// bit-serial remainder unit, move decode and output register
// depends on wbml_pkg
`default_nettype none

module wbml_datapath #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_index_i,
  input  wire logic [wbml_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic [wbml_pkg::SLOT_W-1:0]          entry_index_i,
  input  wire logic [wbml_pkg::KEY_W-1:0]           entry_key_i,
  input  wire logic [wbml_pkg::MOVE_W-1:0]          entry_move_i,
  input  wire logic [wbml_pkg::WEIGHT_W-1:0]        entry_weight_i,
  input  wire logic [wbml_pkg::KEY_W-1:0]           search_key_i,
  input  wire logic [63:0]                          king_mask_i,
  input  wbml_pkg::cmd_t                            cmd_i,
  output wbml_pkg::sts_t                            sts_o,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [1:0]                                status_o,
  output logic [wbml_pkg::SQUARE_W-1:0]             from_square_o,
  output logic [wbml_pkg::SQUARE_W-1:0]             to_square_o,
  output logic [wbml_pkg::TOTAL_W-1:0]              total_weight_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TOT_W = wbml_pkg::WEIGHT_W + CNT_W;

  // table memory, one write and one registered read port
  wbml_pkg::entry_t mem_q [TABLE_DEPTH];
  wbml_pkg::entry_t rd_q;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_ok;

  // configuration state
  logic [CNT_W-1:0]                n_q;
  logic [wbml_pkg::SEED_W-1:0]     rand_q, rand_d;
  logic [31:0]                     cnt_ext;

  // query registers
  logic [wbml_pkg::KEY_W-1:0]      key_q;
  logic [63:0]                     kmask_q;
  logic [CNT_W-1:0]                left_q, right_q, pos_q;
  logic [CNT_W-1:0]                mid, pos_inc;
  logic [TOT_W-1:0]                total_q;
  logic [TOT_W-1:0]                rem_q, rem_d;
  logic [TOT_W:0]                  rem_sh;
  logic [wbml_pkg::RAND_BIT_W-1:0] bit_q;
  logic [wbml_pkg::MOVE_W-1:0]     sel_move_q;
  logic                            found_q, found_d, hit;
  wbml_pkg::status_e               status_q;

  // output register
  logic                            out_valid_q;
  logic [1:0]                      status_out_q;
  logic [wbml_pkg::SQUARE_W-1:0]   from_out_q, to_out_q;
  logic [wbml_pkg::TOTAL_W-1:0]    total_out_q;

  // move decode
  logic [2:0]                      tx, sx, ty, sy, tx_fix;
  logic [wbml_pkg::SQUARE_W-1:0]   from_sq, to_sq;
  logic [63:0]                     tot_ext;
  logic [wbml_pkg::TOTAL_W-1:0]    total_sat;

  assign wr_addr = IDX_W'(entry_index_i);
  assign wr_ok   = 32'(entry_index_i) < 32'(TABLE_DEPTH);

  assign mid     = left_q + ((right_q - left_q) >> 1);
  assign pos_inc = pos_q + CNT_W'(1);

  // read address selection
  always_comb begin
    unique case (cmd_i.rd_sel)
      wbml_pkg::RD_MID:  rd_addr = mid[IDX_W-1:0];
      wbml_pkg::RD_LEFT: rd_addr = left_q[IDX_W-1:0];
      wbml_pkg::RD_NEXT: rd_addr = pos_inc[IDX_W-1:0];
      default:           rd_addr = left_q[IDX_W-1:0];
    endcase
  end

  // memory write on load items
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) begin
      mem_q[wr_addr] <= '{key: entry_key_i, move: entry_move_i, weight: entry_weight_i};
    end
  end

  // registered memory read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // lfsr step, shift left with feedback into bit 0
  assign rand_d = {rand_q[wbml_pkg::SEED_W-2:0],
                   rand_q[wbml_pkg::LFSR_TAP_HI] ^ rand_q[wbml_pkg::LFSR_TAP_LO]};

  // entry count saturated to the depth on write
  assign cnt_ext = 32'(cfg_wdata_i[wbml_pkg::ENTRY_COUNT_W-1:0]);

  // configuration registers and random state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      rand_q <= wbml_pkg::SEED_RESET;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          wbml_pkg::REG_ENTRY_COUNT: begin
            n_q <= (cnt_ext > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cnt_ext);
          end
          wbml_pkg::REG_RANDOM_SEED: begin
            rand_q <= cfg_wdata_i[wbml_pkg::SEED_W-1:0];
          end
          default: begin
          end
        endcase
      end else if (cmd_i.scan_step) begin
        rand_q <= rand_d;
      end
    end
  end

  // one restoring remainder step: random value mod running total
  assign rem_sh = {rem_q, rand_q[bit_q]};
  always_comb begin
    if (rem_sh >= {1'b0, total_q}) begin
      rem_d = TOT_W'(rem_sh - {1'b0, total_q});
    end else begin
      rem_d = TOT_W'(rem_sh);
    end
  end

  assign hit     = rem_q < TOT_W'(rd_q.weight);
  assign found_d = found_q | (cmd_i.sel_step & hit);

  // search, scan and remainder registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_init) begin
      key_q   <= search_key_i;
      kmask_q <= king_mask_i;
      left_q  <= '0;
      right_q <= n_q - CNT_W'(1);
      total_q <= '0;
    end
    if (cmd_i.srch_upd) begin
      if (key_q <= rd_q.key) begin
        right_q <= mid;
      end else begin
        left_q <= mid + CNT_W'(1);
      end
    end
    if (cmd_i.pos_init) begin
      pos_q <= left_q;
    end else if (cmd_i.sel_step) begin
      pos_q <= pos_inc;
    end
    if (cmd_i.scan_step) begin
      total_q <= total_q + TOT_W'(rd_q.weight);
      rem_q   <= '0;
      bit_q   <= wbml_pkg::RAND_BIT_W'(wbml_pkg::SEED_W - 1);
    end else if (cmd_i.mod_step) begin
      rem_q <= rem_d;
      bit_q <= bit_q - wbml_pkg::RAND_BIT_W'(1);
    end
    if (cmd_i.sel_step && hit) begin
      sel_move_q <= rd_q.move;
    end
  end

  // found flag and status code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      status_q <= wbml_pkg::ST_EMPTY;
    end else begin
      if (cmd_i.q_init) begin
        found_q <= 1'b0;
      end else begin
        found_q <= found_d;
      end
      unique case (cmd_i.stat_op)
        wbml_pkg::STAT_NONE:     status_q <= status_q;
        wbml_pkg::STAT_EMPTY:    status_q <= wbml_pkg::ST_EMPTY;
        wbml_pkg::STAT_ZERO:     status_q <= wbml_pkg::ST_ZERO_WEIGHT;
        wbml_pkg::STAT_SCAN_END: begin
          status_q <= found_d ? wbml_pkg::ST_FOUND : wbml_pkg::ST_NO_ENTRY;
        end
        default:                 status_q <= status_q;
      endcase
    end
  end

  // move decode with rank flip and castling fix
  assign tx      = sel_move_q[2:0] & wbml_pkg::FIELD_MASK3;
  assign ty      = ~(sel_move_q[5:3] & wbml_pkg::FIELD_MASK3);
  assign sx      = sel_move_q[8:6] & wbml_pkg::FIELD_MASK3;
  assign sy      = ~(sel_move_q[11:9] & wbml_pkg::FIELD_MASK3);
  assign from_sq = {sy, sx};

  always_comb begin
    tx_fix = tx;
    if (kmask_q[from_sq] && sx == wbml_pkg::FILE_E) begin
      if (tx == wbml_pkg::FILE_A) begin
        tx_fix = wbml_pkg::FILE_C;
      end else if (tx == wbml_pkg::FILE_H) begin
        tx_fix = wbml_pkg::FILE_G;
      end
    end
  end

  assign to_sq     = {ty, tx_fix};
  assign tot_ext   = 64'(total_q);
  assign total_sat = (tot_ext > 64'(wbml_pkg::WEIGHT_SAT)) ? wbml_pkg::WEIGHT_SAT
                                                           : wbml_pkg::TOTAL_W'(tot_ext);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_out_q <= status_q;
      if (status_q == wbml_pkg::ST_FOUND) begin
        from_out_q  <= from_sq;
        to_out_q    <= to_sq;
        total_out_q <= total_sat;
      end else begin
        from_out_q  <= '0;
        to_out_q    <= '0;
        total_out_q <= '0;
      end
    end
  end

  // status towards the controller
  assign sts_o.n_zero   = (n_q == '0);
  assign sts_o.lt       = (left_q < right_q);
  assign sts_o.key_eq   = (rd_q.key == key_q);
  assign sts_o.w_zero   = (rd_q.weight == '0);
  assign sts_o.mod_last = (bit_q == '0);
  assign sts_o.more     = (pos_inc < n_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_out_q;
  assign from_square_o  = from_out_q;
  assign to_square_o    = to_out_q;
  assign total_weight_o = total_out_q;

endmodule

`default_nettype wire

>>> sv/weighted_book_move_lookup_top.sv
// Weighted opening book move lookup. A load item (tuser 0) writes one table
// slot when it is taken. A query item (tuser 1) runs a lower-bound binary
// search over the slots in use, each halving one table read and one key
// compare, then for each entry of the matching run steps the lfsr, forms the
// bit-serial remainder of the 31-bit random value by the running weight sum
// and takes the pick decision. One result item per query, none per load;
// queries are handled one at a time, and the next item is taken while a result
// waits in the output register. Whoever loads the table must keep it sorted by
// key; the block does not enforce this. Writing random_seed reloads the lfsr.
//
// weighted_book_move_lookup_top: top level, stream ports and configuration port
// depends on wbml_pkg, wbml_ctrl, wbml_datapath
`default_nettype none

module weighted_book_move_lookup_top #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // configuration write port
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_index_i,
  input  wire logic [30:0]   cfg_wdata_i,
  // input items
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // entry_index[11:0], entry_key[75:12], entry_move[91:76], entry_weight[107:92],
  // search_key[171:108], king_mask[235:172], zero fill[239:236]
  input  wire logic [239:0]  s_axis_tdata,
  // opcode[0]
  input  wire logic          s_axis_tuser,
  // result items
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // from_square[5:0], to_square[11:6], total_weight[39:12]
  output logic [39:0]        m_axis_tdata,
  // status[1:0]
  output logic [1:0]         m_axis_tuser
);

  wbml_pkg::cmd_t cmd;
  wbml_pkg::sts_t sts;

  logic [wbml_pkg::SQUARE_W-1:0] from_sq, to_sq;
  logic [wbml_pkg::TOTAL_W-1:0]  total_w;

  // controller
  wbml_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  wbml_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .entry_index_i  (s_axis_tdata[11:0]),
    .entry_key_i    (s_axis_tdata[75:12]),
    .entry_move_i   (s_axis_tdata[91:76]),
    .entry_weight_i (s_axis_tdata[107:92]),
    .search_key_i   (s_axis_tdata[171:108]),
    .king_mask_i    (s_axis_tdata[235:172]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .status_o       (m_axis_tuser),
    .from_square_o  (from_sq),
    .to_square_o    (to_sq),
    .total_weight_o (total_w)
  );

  // result packing
  assign m_axis_tdata = {total_w, to_sq, from_sq};

endmodule

`default_nettype wire

>>> sim/tb.sv
// tb: self-checking bench for the weighted book move lookup, stream and config ports
// carries its own lookup model; items and results are checked in order
// depends on wbml_pkg and weighted_book_move_lookup_top
`timescale 1ns / 1ps

module tb;
  import wbml_pkg::*;

  localparam int unsigned BOOK_DEPTH    = 4096;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 500;
  localparam int unsigned HOLD_AFTER    = 40;
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_QUERIES = 45;

  // one input item, all fields kept whatever the opcode
  typedef struct {
    op_e         op;
    logic [11:0] slot;
    logic [63:0] key;
    logic [15:0] move;
    logic [15:0] weight;
    logic [63:0] skey;
    logic [63:0] kmask;
  } book_item_t;

  // one result item
  typedef struct packed {
    status_e     status;
    logic [5:0]  from_sq;
    logic [5:0]  to_sq;
    logic [27:0] total;
  } book_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // directed stimulus row: an item, or a register write taken while idle
  typedef struct {
    row_kind_e   kind;
    book_item_t  item;
    bit          typed;
    status_e     err_st;
    cfg_reg_e    cfg_sel;
    logic [30:0] cfg_val;
  } book_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           cfg_we;
  cfg_reg_e       cfg_index;
  logic [30:0]    cfg_wdata;
  logic           s_tvalid;
  logic           s_tready;
  logic [239:0]   s_tdata;
  logic           s_tuser;
  logic           m_tvalid;
  logic           m_tready;
  logic [39:0]    m_tdata;
  logic [1:0]     m_tuser;

  weighted_book_move_lookup_top #(
    .TABLE_DEPTH(BOOK_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // model state: table copy, count, lfsr
  logic [63:0] mdl_key    [BOOK_DEPTH];
  logic [15:0] mdl_move   [BOOK_DEPTH];
  logic [15:0] mdl_weight [BOOK_DEPTH];
  logic [12:0] mdl_count;
  logic [30:0] mdl_lfsr;

  book_result_t book_expect_q[$];
  int           n_bad        = 0;
  int           results_seen = 0;
  int           gap_mode     = 1;
  int unsigned  cycle_cnt    = 0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // lower-bound search, weighted pick over the run of equal keys, move decode
  function automatic book_result_t lookup_move(input logic [63:0] skey,
                                               input logic [63:0] kmask);
    int unsigned     n, lo, hi, mid, pos;
    longint unsigned total, w, rnd;
    logic [15:0]     pick;
    bit              found;
    logic [2:0]      tx, ty, sx, sy;
    book_result_t    res;
    res = '{status: ST_NO_ENTRY, from_sq: '0, to_sq: '0, total: '0};
    n = (mdl_count > BOOK_DEPTH) ? BOOK_DEPTH : mdl_count;
    if (n == 0) begin
      res.status = ST_EMPTY;
      return res;
    end
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (skey <= mdl_key[mid]) hi = mid;
      else lo = mid + 1;
    end
    if (mdl_key[lo] != skey) return res;
    total = 0;
    found = 1'b0;
    pick  = '0;
    for (pos = lo; pos < n && mdl_key[pos] == skey; pos++) begin
      w = mdl_weight[pos];
      if (w == 0) begin
        res.status = ST_ZERO_WEIGHT;
        return res;
      end
      total += w;
      mdl_lfsr = {mdl_lfsr[29:0], mdl_lfsr[LFSR_TAP_HI] ^ mdl_lfsr[LFSR_TAP_LO]};
      rnd = mdl_lfsr;
      if (rnd % total < w) begin
        pick  = mdl_move[pos];
        found = 1'b1;
      end
    end
    if (!found) return res;
    // ranks stored flipped
    tx = pick[2:0];
    ty = 3'd7 - pick[5:3];
    sx = pick[8:6];
    sy = 3'd7 - pick[11:9];
    // castling written as king takes rook
    if (kmask[{sy, sx}] && sx == FILE_E) begin
      if (tx == FILE_A) tx = FILE_C;
      else if (tx == FILE_H) tx = FILE_G;
    end
    res.status  = ST_FOUND;
    res.from_sq = {sy, sx};
    res.to_sq   = {ty, tx};
    res.total   = (total > WEIGHT_SAT) ? WEIGHT_SAT : total[27:0];
    return res;
  endfunction

  function automatic book_item_t load_item(input logic [11:0] slot, input logic [63:0] key,
                                           input logic [15:0] mv, input logic [15:0] wt);
    book_item_t it;
    it.op     = OP_LOAD;
    it.slot   = slot;
    it.key    = key;
    it.move   = mv;
    it.weight = wt;
    it.skey   = rand64();
    it.kmask  = rand64();
    return it;
  endfunction

  function automatic book_item_t query_item(input logic [63:0] skey, input logic [63:0] kmask);
    book_item_t it;
    it.op     = OP_QUERY;
    it.slot   = 12'($urandom);
    it.key    = rand64();
    it.move   = 16'($urandom);
    it.weight = 16'($urandom);
    it.skey   = skey;
    it.kmask  = kmask;
    return it;
  endfunction

  function automatic book_row_t item_row(input book_item_t it, input bit typed,
                                         input status_e st);
    book_row_t row;
    row.kind   = ROW_ITEM;
    row.item   = it;
    row.typed  = typed;
    row.err_st = st;
    return row;
  endfunction

  function automatic book_row_t cfg_row(input cfg_reg_e sel, input logic [30:0] val);
    book_row_t row;
    row.kind    = ROW_CFG;
    row.cfg_sel = sel;
    row.cfg_val = val;
    row.typed   = 1'b0;
    return row;
  endfunction

  // sender gap: mostly none, a few long
  function automatic int pick_gap();
    int r;
    if (gap_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one item, wait for the handshake, then update the model
  task automatic send_item(input book_item_t it, input bit typed, input status_e err_st);
    int           gap;
    book_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tdata  <= {4'b0, it.kmask, it.skey, it.weight, it.move, it.key, it.slot};
    s_tuser  <= it.op;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    if (it.op == OP_LOAD) begin
      mdl_key[it.slot]    = it.key;
      mdl_move[it.slot]   = it.move;
      mdl_weight[it.slot] = it.weight;
    end else begin
      res = lookup_move(it.skey, it.kmask);
      if (typed) res = '{status: err_st, from_sq: '0, to_sq: '0, total: '0};
      book_expect_q.push_back(res);
    end
  endtask

  // drain all results, then let the block go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (book_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (sel == REG_ENTRY_COUNT) mdl_count = val[12:0];
    else mdl_lfsr = val;
    @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    book_row_t   dir_rows[$];
    logic [63:0] k, km, fk;
    logic [15:0] mv, wt;
    int          n, r;
    cfg_we    = 1'b0;
    cfg_index = REG_ENTRY_COUNT;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_LOAD;
    rst_ni    = 1'b0;
    mdl_count = '0;
    mdl_lfsr  = SEED_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, zero weight, missing keys, castling, seed extremes
    dir_rows.push_back(item_row(query_item('0, '0), 1'b1, ST_EMPTY));
    dir_rows.push_back(item_row(query_item('1, '1), 1'b1, ST_EMPTY));
    dir_rows.push_back(item_row(load_item(12'd0, 64'd0, 16'h0000, 16'hFFFF), 1'b0, ST_FOUND));
    dir_rows.push_back(item_row(load_item(12'd1, 64'd5, 16'h0FFF, 16'h0000), 1'b0, ST_FOUND));
    // e1 to a1 and e1 to h1, the latter with the unused top bits set
    dir_rows.push_back(item_row(load_item(12'd2, 64'd9, 16'h0F38, 16'h0001), 1'b0, ST_FOUND));
    dir_rows.push_back(item_row(load_item(12'd3, 64'd9, 16'hFF3F, 16'h0002), 1'b0, ST_FOUND));
    dir_rows.push_back(item_row(load_item(12'd4, 64'd12, 16'h1234, 16'h0007), 1'b0, ST_FOUND));
    dir_rows.push_back(item_row(load_item(12'd5, 64'd12, 16'h0000, 16'h0000), 1'b0, ST_FOUND));
    // e8 to h8
    dir_rows.push_back(item_row(load_item(12'd6, 64'd40, 16'h0107, 16'hFFFF), 1'b0, ST_FOUND));
    dir_rows.push_back(item_row(load_item(12'd7, '1, 16'hFFFF, 16'hFFFF), 1'b0, ST_FOUND));
    dir_rows.push_back(cfg_row(REG_ENTRY_COUNT, 31'd8));
    dir_rows.push_back(item_row(query_item(64'd0, '0), 1'b0, ST_FOUND));
    dir_rows.push_back(cfg_row(REG_RANDOM_SEED, 31'h7FFFFFFF));
    dir_rows.push_back(item_row(query_item(64'd0, '0), 1'b0, ST_FOUND));
    dir_rows.push_back(item_row(query_item(64'd5, '1), 1'b1, ST_ZERO_WEIGHT));
    dir_rows.push_back(item_row(query_item(64'd3, '0), 1'b1, ST_NO_ENTRY));
    dir_rows.push_back(item_row(query_item(64'd9, 64'h10), 1'b0, ST_FOUND));
    dir_rows.push_back(item_row(query_item(64'd9, '0), 1'b0, ST_FOUND));
    dir_rows.push_back(item_row(query_item(64'd12, '1), 1'b1, ST_ZERO_WEIGHT));
    dir_rows.push_back(item_row(query_item(64'd40, 64'h1000_0000_0000_0000), 1'b0, ST_FOUND));
    dir_rows.push_back(item_row(query_item('1, '1), 1'b0, ST_FOUND));
    dir_rows.push_back(item_row(query_item(64'hFFFF_FFFF_FFFF_FFFE, '0), 1'b1, ST_NO_ENTRY));
    // zero seed: the last match of a run always wins
    dir_rows.push_back(cfg_row(REG_RANDOM_SEED, 31'd0));
    dir_rows.push_back(item_row(query_item(64'd9, 64'h10), 1'b0, ST_FOUND));
    dir_rows.push_back(item_row(query_item(64'd40, '1), 1'b0, ST_FOUND));
    // single entry in use
    dir_rows.push_back(cfg_row(REG_ENTRY_COUNT, 31'd1));
    dir_rows.push_back(item_row(query_item(64'd5, '0), 1'b1, ST_NO_ENTRY));
    dir_rows.push_back(item_row(query_item(64'd0, '0), 1'b0, ST_FOUND));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].cfg_sel, dir_rows[i].cfg_val);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].err_st);
      end
    end

    // count of zero again, loads still land
    settle();
    write_reg(REG_ENTRY_COUNT, 31'd0);
    write_reg(REG_RANDOM_SEED, 31'($urandom_range(1, 32'h7FFFFFFF)));
    repeat (8) begin
      if ($urandom_range(0, 2) == 0)
        send_item(load_item(12'($urandom), rand64(), 16'($urandom), 16'($urandom)),
                  1'b0, ST_FOUND);
      else
        send_item(query_item(rand64(), rand64()), 1'b1, ST_EMPTY);
    end

    // full table of one key at top weight, count beyond depth saturates
    settle();
    gap_mode = $urandom_range(0, 2);
    write_reg(REG_ENTRY_COUNT, 31'h1FFF);
    write_reg(REG_RANDOM_SEED, 31'($urandom_range(1, 32'h7FFFFFFF)));
    fk = rand64();
    fk[1:0] = 2'b01;
    for (int i = 0; i < BOOK_DEPTH; i++)
      send_item(load_item(12'(i), fk, 16'($urandom), 16'hFFFF), 1'b0, ST_FOUND);
    send_item(query_item(fk, rand64()), 1'b0, ST_FOUND);
    send_item(query_item(fk - 64'd1, rand64()), 1'b1, ST_NO_ENTRY);
    send_item(query_item(fk + 64'd1, rand64()), 1'b1, ST_NO_ENTRY);
    settle();
    write_reg(REG_ENTRY_COUNT, 31'(BOOK_DEPTH));
    send_item(load_item(12'hFFF, '1, 16'($urandom), 16'($urandom_range(1, 65535))),
              1'b0, ST_FOUND);
    send_item(query_item('1, rand64()), 1'b0, ST_FOUND);
    send_item(query_item(fk + 64'd1, rand64()), 1'b1, ST_NO_ENTRY);

    // random phases: sorted tables with runs, mostly hitting queries, some noise
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      gap_mode = $urandom_range(0, 2);
      n = (ph == 2) ? 1 : (ph == 5) ? 128 : $urandom_range(2, 48);
      write_reg(REG_ENTRY_COUNT, 31'(n));
      if (ph == 1) write_reg(REG_RANDOM_SEED, 31'h7FFFFFFF);
      else if (ph == 3) write_reg(REG_RANDOM_SEED, 31'd0);
      else if (ph != 4) write_reg(REG_RANDOM_SEED, 31'($urandom_range(1, 32'h7FFFFFFF)));
      k = rand64();
      for (int i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(0, 99) >= 40) k = k + 64'($urandom_range(1, 3000));
        r  = $urandom_range(0, 99);
        wt = (r < 6) ? 16'h0000 : (r < 12) ? 16'hFFFF : (r < 18) ? 16'h0001 : 16'($urandom);
        // a quarter of the moves leave the e file for a or h
        if ($urandom_range(0, 3) == 0)
          mv = {4'($urandom), 3'($urandom), FILE_E, 3'($urandom),
                ($urandom_range(0, 1) != 0) ? FILE_H : FILE_A};
        else
          mv = 16'($urandom);
        send_item(load_item(12'(i), k, mv, wt), 1'b0, ST_FOUND);
      end
      for (int j = 0; j < PHASE_QUERIES; j++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          // overwrite inside the used range, order no longer kept
          send_item(load_item(12'($urandom_range(0, n - 1)), rand64(), 16'($urandom),
                              16'($urandom)), 1'b0, ST_FOUND);
        end else if (r < 8) begin
          send_item(load_item(12'($urandom), rand64(), 16'($urandom), 16'($urandom)),
                    1'b0, ST_FOUND);
        end else begin
          r = $urandom_range(0, 99);
          k = mdl_key[$urandom_range(0, n - 1)];
          if (r >= 90) k = rand64();
          else if (r >= 80) k = k + 64'd1;
          else if (r >= 75) k = k - 64'd1;
          r  = $urandom_range(0, 99);
          km = (r < 20) ? '1 : (r < 30) ? '0 : rand64();
          send_item(query_item(k, km), 1'b0, ST_FOUND);
        end
      end
    end

    settle();
    if (n_bad == 0 && book_expect_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // receiver: stretches of random stalls or none, one long hold-off
  initial begin
    int stall;
    int burst;
    bit held;
    stall    = 0;
    held     = 1'b0;
    m_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      burst = $urandom_range(0, 3);
      repeat ($urandom_range(50, 300)) begin
        if (stall > 0) begin
          stall--;
          m_tready <= 1'b0;
        end else if (burst != 0 && $urandom_range(0, 99) < 25) begin
          stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
        @(posedge clk_i);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    book_result_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.status  = status_e'(m_tuser);
      got.from_sq = m_tdata[5:0];
      got.to_sq   = m_tdata[11:6];
      got.total   = m_tdata[39:12];
      results_seen++;
      if (book_expect_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t: result with nothing outstanding: status %0d from %0d to %0d total %0d",
                   $realtime, got.status, got.from_sq, got.to_sq, got.total);
      end else begin
        want = book_expect_q.pop_front();
        if (got.status != want.status || got.from_sq != want.from_sq ||
            got.to_sq != want.to_sq || got.total != want.total) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: mismatch exp/act status %0d/%0d from %0d/%0d to %0d/%0d total %0d/%0d",
                     $realtime, want.status, got.status, want.from_sq, got.from_sq,
                     want.to_sq, got.to_sq, want.total, got.total);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
